/* hdl/tesp_pkg.sv */
// ----------------------------------------------------------------------------
// tesp_pkg - shared types and constants of the escape sequence parser
// token kinds, byte codes, queue entry and handshake structs
// ----------------------------------------------------------------------------
`default_nettype none

package tesp_pkg;

  // csi parameter slots
  localparam int PARAMS = 16;
  localparam int PIDX_W = $clog2(PARAMS);
  localparam int PCNT_W = $clog2(PARAMS + 1);

  // token queue between parser and emitter, power of two
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // token kinds
  localparam logic [3:0] K_TEXT      = 4'd0;
  localparam logic [3:0] K_CTRL      = 4'd1;
  localparam logic [3:0] K_ESC       = 4'd2;
  localparam logic [3:0] K_SS3       = 4'd3;
  localparam logic [3:0] K_CSI_PARAM = 4'd4;
  localparam logic [3:0] K_CSI_END   = 4'd5;
  localparam logic [3:0] K_OSC_DATA  = 4'd6;
  localparam logic [3:0] K_OSC_END   = 4'd7;
  localparam logic [3:0] K_DCS_DATA  = 4'd8;
  localparam logic [3:0] K_DCS_END   = 4'd9;

  // input op codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // byte codes
  localparam logic [7:0] C_BEL   = 8'h07;
  localparam logic [7:0] C_ESC   = 8'h1B;
  localparam logic [7:0] C_SPACE = 8'h20;
  localparam logic [7:0] C_DEL   = 8'h7F;
  localparam logic [7:0] C_BSL   = 8'h5C;
  localparam logic [7:0] C_SEMI  = 8'h3B;
  localparam logic [7:0] C_ZERO  = 8'h30;
  localparam logic [7:0] C_NINE  = 8'h39;
  localparam logic [7:0] C_PRIV0 = 8'h3C;
  localparam logic [7:0] C_PRIV1 = 8'h3F;
  localparam logic [7:0] C_FIN0  = 8'h40;
  localparam logic [7:0] C_FIN1  = 8'h7E;

  localparam logic [20:0] CP_CSI  = 21'h5B;
  localparam logic [20:0] CP_OSC  = 21'h5D;
  localparam logic [20:0] CP_SS3  = 21'h4F;
  localparam logic [20:0] CP_DCS  = 21'h50;
  localparam logic [20:0] CP_REPL = 21'hFFFD;

  localparam logic [15:0] PV_MAX = 16'hFFFF;

  typedef struct packed {
    logic [3:0]        kind;
    logic [7:0]        ch;
    logic [PCNT_W-1:0] total;
    logic [7:0]        priv;
    logic              last;
  } entry_t;

  typedef struct packed {
    logic   v0;
    logic   v1;
    entry_t e0;
    entry_t e1;
  } push_t;

  typedef struct packed {
    logic [QCW-1:0] free;
    logic           head_v;
    entry_t         head;
  } qstat_t;

  typedef struct packed {
    logic              we;
    logic [PIDX_W-1:0] addr;
    logic [15:0]       data;
  } pwrite_t;

endpackage

`default_nettype wire

/* hdl/tesp_if.sv */
// ----------------------------------------------------------------------------
// tesp_if - channel interfaces of the escape sequence parser
// input byte channel and token result channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface tesp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, op, data_byte, input ready);
  modport sink   (input valid, op, data_byte, output ready);
endinterface

interface tesp_out_if;
  logic                        valid;
  logic                        ready;
  logic [3:0]                  kind;
  logic [7:0]                  char_value;
  logic [3:0]                  param_index;
  logic [15:0]                 param_value;
  logic [tesp_pkg::PCNT_W-1:0] param_total;
  logic [7:0]                  private_marker;
  logic                        last_of_run;

  modport source (output valid, kind, char_value, param_index, param_value,
                  param_total, private_marker, last_of_run, input ready);
  modport sink   (input valid, kind, char_value, param_index, param_value,
                  param_total, private_marker, last_of_run, output ready);
endinterface

`default_nettype wire

/* hdl/tesp_ram.sv */
// ----------------------------------------------------------------------------
// tesp_ram - generic single write, single read ram
// registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tesp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* hdl/tesp_front.sv */
// ----------------------------------------------------------------------------
// tesp_front - byte classifier of the escape sequence parser
// mode machine, utf-8 decode, csi parameter collection, token push
// ----------------------------------------------------------------------------
`default_nettype none

module tesp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  tesp_in_if.sink               in_ch,
  input  wire tesp_pkg::qstat_t qstat,
  input  wire logic             csi_done,
  output tesp_pkg::push_t       push,
  output tesp_pkg::pwrite_t     pw
);

  typedef enum logic [3:0] {
    M_GROUND, M_ESC, M_ESC_U8, M_SS3, M_SS3_U8,
    M_CSI, M_OSC, M_DCS, M_OSC_ESC, M_DCS_ESC
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic       v;
    logic [3:0] kind;
    logic [7:0] ch;
  } step_t;

  function automatic step_t f_got_char(logic [20:0] cp, logic ss3);
    step_t s;
    s.mode = M_GROUND;
    s.v    = 1'b0;
    s.kind = tesp_pkg::K_ESC;
    s.ch   = cp[7:0];
    if (ss3) begin
      s.v    = 1'b1;
      s.kind = tesp_pkg::K_SS3;
    end else begin
      case (cp)
        tesp_pkg::CP_CSI: s.mode = M_CSI;
        tesp_pkg::CP_OSC: s.mode = M_OSC;
        tesp_pkg::CP_SS3: s.mode = M_SS3;
        tesp_pkg::CP_DCS: s.mode = M_DCS;
        default:          s.v    = 1'b1;
      endcase
    end
    return s;
  endfunction

  function automatic step_t f_ground(logic [7:0] b);
    step_t s;
    s.mode = M_GROUND;
    s.v    = 1'b1;
    s.ch   = b;
    s.kind = tesp_pkg::K_TEXT;
    if (b == tesp_pkg::C_ESC) begin
      s.mode = M_ESC;
      s.v    = 1'b0;
    end else if (b < tesp_pkg::C_SPACE || b == tesp_pkg::C_DEL) begin
      s.kind = tesp_pkg::K_CTRL;
    end
    return s;
  endfunction

  function automatic step_t f_string(logic [7:0] b, logic osc);
    step_t s;
    s.mode = osc ? M_OSC : M_DCS;
    s.v    = 1'b1;
    s.ch   = b;
    s.kind = osc ? tesp_pkg::K_OSC_DATA : tesp_pkg::K_DCS_DATA;
    if (b == tesp_pkg::C_BEL) begin
      s.mode = M_GROUND;
      s.ch   = 8'h00;
      s.kind = osc ? tesp_pkg::K_OSC_END : tesp_pkg::K_DCS_END;
    end else if (b == tesp_pkg::C_ESC) begin
      s.mode = osc ? M_OSC_ESC : M_DCS_ESC;
      s.v    = 1'b0;
    end
    return s;
  endfunction

  mode_t                       mode_r, mode_nxt;
  logic [1:0]                  rem_r, rem_nxt;
  logic [20:0]                 acc_r, acc_nxt;
  logic [tesp_pkg::PCNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]                 cur_r, cur_nxt;
  logic [7:0]                  priv_r, priv_nxt;
  logic                        pend_r;

  step_t                       s0, s1, g;
  logic                        csi_end;
  logic [tesp_pkg::PCNT_W-1:0] csi_total;
  logic                        we;
  logic [19:0]                 prod;
  logic [20:0]                 acc_sh;
  logic [1:0]                  rem_dec;
  logic                        cnt_room;
  logic [7:0]                  b;
  logic                        fire;

  assign b        = in_ch.data_byte;
  assign in_ch.ready = (qstat.free >= tesp_pkg::QCW'(2)) && !pend_r;
  assign fire     = in_ch.valid && in_ch.ready;
  assign cnt_room = cnt_r < tesp_pkg::PCNT_W'(tesp_pkg::PARAMS);
  assign prod     = {1'b0, cur_r, 3'b000} + {3'b000, cur_r, 1'b0}
                  + {16'h0000, b[3:0] - tesp_pkg::C_ZERO[3:0]};
  assign acc_sh   = {acc_r[14:0], b[5:0]};
  assign rem_dec  = (rem_r != 2'd0) ? rem_r - 2'd1 : 2'd0;

  always_comb begin
    mode_nxt  = mode_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    priv_nxt  = priv_r;
    s0        = '{mode: M_GROUND, v: 1'b0, kind: tesp_pkg::K_TEXT, ch: 8'h00};
    s1        = s0;
    g         = s0;
    csi_end   = 1'b0;
    csi_total = cnt_r;
    we        = 1'b0;
    if (in_ch.op == tesp_pkg::OP_TIMEOUT) begin
      if (mode_r == M_ESC) begin
        mode_nxt = M_GROUND;
        s0.v     = 1'b1;
        s0.kind  = tesp_pkg::K_ESC;
      end
    end else begin
      case (mode_r)
        M_ESC, M_SS3: begin
          if (!b[7]) begin
            g = f_got_char({13'h0, b}, mode_r == M_SS3);
            mode_nxt = g.mode;
            s0 = g;
          end else if (b[7:5] == 3'b110) begin
            rem_nxt  = 2'd1;
            acc_nxt  = {16'h0, b[4:0]};
            mode_nxt = (mode_r == M_SS3) ? M_SS3_U8 : M_ESC_U8;
          end else if (b[7:4] == 4'b1110) begin
            rem_nxt  = 2'd2;
            acc_nxt  = {17'h0, b[3:0]};
            mode_nxt = (mode_r == M_SS3) ? M_SS3_U8 : M_ESC_U8;
          end else if (b[7:3] == 5'b11110) begin
            rem_nxt  = 2'd3;
            acc_nxt  = {18'h0, b[2:0]};
            mode_nxt = (mode_r == M_SS3) ? M_SS3_U8 : M_ESC_U8;
          end else begin
            g = f_got_char(tesp_pkg::CP_REPL, mode_r == M_SS3);
            mode_nxt = g.mode;
            s0 = g;
          end
        end
        M_ESC_U8, M_SS3_U8: begin
          if (b[7:6] != 2'b10) begin
            // broken sequence: replacement char, then the byte again in ground
            rem_nxt  = 2'd0;
            acc_nxt  = 21'h0;
            s0       = f_got_char(tesp_pkg::CP_REPL, mode_r == M_SS3_U8);
            s1       = f_ground(b);
            mode_nxt = s1.mode;
          end else begin
            rem_nxt = rem_dec;
            acc_nxt = acc_sh;
            if (rem_dec == 2'd0) begin
              acc_nxt  = 21'h0;
              g        = f_got_char(acc_sh, mode_r == M_SS3_U8);
              mode_nxt = g.mode;
              s0       = g;
            end
          end
        end
        M_CSI: begin
          if (b >= tesp_pkg::C_ZERO && b <= tesp_pkg::C_NINE) begin
            if (cnt_room) begin
              cur_nxt = (prod[19:16] != 4'h0) ? tesp_pkg::PV_MAX : prod[15:0];
            end
          end else if (b >= tesp_pkg::C_FIN0 && b <= tesp_pkg::C_FIN1) begin
            mode_nxt = M_GROUND;
            csi_end  = 1'b1;
            s0.v     = 1'b1;
            s0.kind  = tesp_pkg::K_CSI_END;
            s0.ch    = b;
            if ((cnt_r != '0 || cur_r != 16'h0) && cnt_room) begin
              we        = 1'b1;
              csi_total = cnt_r + tesp_pkg::PCNT_W'(1);
            end
            cnt_nxt = csi_total;
          end else if (b == tesp_pkg::C_SEMI) begin
            if (cnt_room) begin
              we      = 1'b1;
              cnt_nxt = cnt_r + tesp_pkg::PCNT_W'(1);
              cur_nxt = 16'h0;
            end
          end else if (b >= tesp_pkg::C_PRIV0 && b <= tesp_pkg::C_PRIV1) begin
            priv_nxt = b;
          end
        end
        M_OSC, M_DCS: begin
          s0       = f_string(b, mode_r == M_OSC);
          mode_nxt = s0.mode;
        end
        M_OSC_ESC, M_DCS_ESC: begin
          if (b == tesp_pkg::C_BSL) begin
            mode_nxt = M_GROUND;
            s0.v     = 1'b1;
            s0.kind  = (mode_r == M_OSC_ESC) ? tesp_pkg::K_OSC_END : tesp_pkg::K_DCS_END;
          end else begin
            // false escape: 0x1b as payload, then the byte as a string byte
            s0.v     = 1'b1;
            s0.kind  = (mode_r == M_OSC_ESC) ? tesp_pkg::K_OSC_DATA : tesp_pkg::K_DCS_DATA;
            s0.ch    = tesp_pkg::C_ESC;
            s1       = f_string(b, mode_r == M_OSC_ESC);
            mode_nxt = s1.mode;
          end
        end
        default: begin
          s0       = f_ground(b);
          mode_nxt = s0.mode;
        end
      endcase
    end
    // entering csi clears the parameter set
    if (mode_nxt == M_CSI && mode_r != M_CSI) begin
      cnt_nxt  = '0;
      cur_nxt  = 16'h0;
      priv_nxt = 8'h00;
    end
  end

  always_comb begin
    push.v0       = fire && s0.v;
    push.v1       = fire && s1.v;
    push.e0.kind  = s0.kind;
    push.e0.ch    = s0.ch;
    push.e0.total = csi_end ? csi_total : '0;
    push.e0.priv  = csi_end ? priv_r : 8'h00;
    push.e0.last  = !s1.v;
    push.e1.kind  = s1.kind;
    push.e1.ch    = s1.ch;
    push.e1.total = '0;
    push.e1.priv  = 8'h00;
    push.e1.last  = 1'b1;
    pw.we         = fire && we;
    pw.addr       = cnt_r[tesp_pkg::PIDX_W-1:0];
    pw.data       = cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_GROUND;
      rem_r  <= 2'd0;
      acc_r  <= 21'h0;
      cnt_r  <= '0;
      cur_r  <= 16'h0;
      priv_r <= 8'h00;
      pend_r <= 1'b0;
    end else begin
      if (fire) begin
        mode_r <= mode_nxt;
        rem_r  <= rem_nxt;
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        cur_r  <= cur_nxt;
        priv_r <= priv_nxt;
      end
      if (fire && csi_end) begin
        pend_r <= 1'b1;
      end else if (csi_done) begin
        pend_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/tesp_queue.sv */
// ----------------------------------------------------------------------------
// tesp_queue - token queue between classifier and emitter
// up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tesp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tesp_pkg::push_t push,
  input  wire logic            pop,
  output tesp_pkg::qstat_t     qstat
);

  tesp_pkg::entry_t             mem_r [tesp_pkg::QDEPTH];
  logic [tesp_pkg::QAW-1:0]     wp_r, rp_r;
  logic [tesp_pkg::QCW-1:0]     cnt_r, cnt_nxt;
  logic [tesp_pkg::QAW-1:0]     wp1;

  assign wp1 = wp_r + tesp_pkg::QAW'(1);

  always_comb begin
    cnt_nxt = cnt_r + tesp_pkg::QCW'(push.v0) + tesp_pkg::QCW'(push.v1)
            - tesp_pkg::QCW'(pop);
    qstat.free   = tesp_pkg::QCW'(tesp_pkg::QDEPTH) - cnt_r;
    qstat.head_v = cnt_r != '0;
    qstat.head   = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wp_r] <= push.e0;
    end
    if (push.v1) begin
      mem_r[wp1] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_r + tesp_pkg::QAW'(push.v0) + tesp_pkg::QAW'(push.v1);
      if (pop) begin
        rp_r <= rp_r + tesp_pkg::QAW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/tesp_back.sv */
// ----------------------------------------------------------------------------
// tesp_back - token emitter of the escape sequence parser
// expands csi ends into parameter runs, drives the output register
// ----------------------------------------------------------------------------
`default_nettype none

module tesp_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tesp_pkg::qstat_t         qstat,
  input  wire logic [15:0]              rd_data,
  output logic [tesp_pkg::PIDX_W-1:0]   rd_addr,
  output logic                          pop,
  output logic                          csi_done,
  tesp_out_if.source                    out_ch
);

  typedef enum logic [1:0] {B_TOKEN, B_PARAM, B_END} bstate_t;

  bstate_t                     state_r, state_nxt;
  logic [tesp_pkg::PIDX_W-1:0] idx_r, idx_nxt;
  logic                        ov_r;
  logic [3:0]                  kind_r, kind_nxt;
  logic [7:0]                  ch_r, ch_nxt;
  logic [3:0]                  pidx_r, pidx_nxt;
  logic [15:0]                 pval_r, pval_nxt;
  logic [tesp_pkg::PCNT_W-1:0] tot_r, tot_nxt;
  logic [7:0]                  priv_r, priv_nxt;
  logic                        last_r, last_nxt;
  logic                        load, slot_free;

  assign slot_free = !ov_r || out_ch.ready;
  assign rd_addr   = idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    load      = 1'b0;
    pop       = 1'b0;
    csi_done  = 1'b0;
    kind_nxt  = qstat.head.kind;
    ch_nxt    = qstat.head.ch;
    pidx_nxt  = 4'h0;
    pval_nxt  = 16'h0;
    tot_nxt   = qstat.head.total;
    priv_nxt  = qstat.head.priv;
    last_nxt  = qstat.head.last;
    case (state_r)
      B_TOKEN: begin
        if (qstat.head_v && slot_free) begin
          if (qstat.head.kind == tesp_pkg::K_CSI_END && qstat.head.total != '0) begin
            state_nxt = B_PARAM;
            idx_nxt   = '0;
          end else begin
            load     = 1'b1;
            pop      = 1'b1;
            csi_done = qstat.head.kind == tesp_pkg::K_CSI_END;
          end
        end
      end
      B_PARAM: begin
        kind_nxt = tesp_pkg::K_CSI_PARAM;
        ch_nxt   = 8'h00;
        pidx_nxt = 4'(idx_r);
        pval_nxt = rd_data;
        tot_nxt  = '0;
        priv_nxt = 8'h00;
        last_nxt = 1'b0;
        if (slot_free) begin
          load = 1'b1;
          if ({1'b0, idx_r} + tesp_pkg::PCNT_W'(1) == qstat.head.total) begin
            state_nxt = B_END;
          end else begin
            idx_nxt = idx_r + tesp_pkg::PIDX_W'(1);
          end
        end
      end
      B_END: begin
        if (slot_free) begin
          load      = 1'b1;
          pop       = 1'b1;
          csi_done  = 1'b1;
          state_nxt = B_TOKEN;
        end
      end
      default: state_nxt = B_TOKEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_TOKEN;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
    if (load) begin
      kind_r <= kind_nxt;
      ch_r   <= ch_nxt;
      pidx_r <= pidx_nxt;
      pval_r <= pval_nxt;
      tot_r  <= tot_nxt;
      priv_r <= priv_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.char_value     = ch_r;
  assign out_ch.param_index    = pidx_r;
  assign out_ch.param_value    = pval_r;
  assign out_ch.param_total    = tot_r;
  assign out_ch.private_marker = priv_r;
  assign out_ch.last_of_run    = last_r;

endmodule

`default_nettype wire

/* hdl/terminal_escape_sequence_parser_unit.sv */
// ----------------------------------------------------------------------------
// terminal_escape_sequence_parser_unit - ansi/vt escape sequence parser
// turns a terminal byte stream into text, control, escape and string tokens
// ----------------------------------------------------------------------------
// usage
//   in_ch takes one beat per byte (op 0) or escape timeout tick (op 1)
//   out_ch gives the token beats that each input beat causes, the last one
//   of them flagged with last_of_run; a csi sequence comes out as one
//   csi_param beat per parameter and then a csi_end beat
// a token passes classifier -> token queue -> output register
// one input beat per cycle while the token queue has room for two tokens and no
//   csi run is pending; a byte that causes two tokens gives two output beats
// a csi final byte holds off input until the emitter loads its csi_end beat:
//   the emitter reads the parameter ram at one entry per cycle while the
//   receiver takes beats
// reset: ground mode, empty queue, no beat on the output
// a stalled receiver keeps its beat in the output register; the queue fills
//   until it has room for fewer than two tokens and then in_ch.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_escape_sequence_parser_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tesp_in_if.sink     in_ch,
  tesp_out_if.source  out_ch
);

  tesp_pkg::push_t             push;
  tesp_pkg::qstat_t            qstat;
  tesp_pkg::pwrite_t           pw;
  logic                        pop;
  logic                        csi_done;
  logic [tesp_pkg::PIDX_W-1:0] rd_addr;
  logic [15:0]                 rd_data;

  // classifier: mode machine and csi parameter collection
  tesp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .qstat    (qstat),
    .csi_done (csi_done),
    .push     (push),
    .pw       (pw)
  );

  // tokens waiting for the emitter
  tesp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .qstat (qstat)
  );

  // csi parameter values, written on ';' and on the final byte
  tesp_ram #(
    .WIDTH (16),
    .DEPTH (tesp_pkg::PARAMS)
  ) u_param_ram (
    .clk   (clk),
    .we    (pw.we),
    .waddr (pw.addr),
    .wdata (pw.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // emitter: output register and parameter run
  tesp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .rd_data  (rd_data),
    .rd_addr  (rd_addr),
    .pop      (pop),
    .csi_done (csi_done),
    .out_ch   (out_ch)
  );

  // parameter ram is never written while a csi end waits at the queue head
  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pw.we |-> !(qstat.head_v && qstat.head.kind == tesp_pkg::K_CSI_END))
    else $error("parameter write during csi drain");

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.free <= tesp_pkg::QCW'(tesp_pkg::QDEPTH))
    else $error("token queue overflow");

  // a second token per byte only comes with a first one
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0 && !push.e0.last)
    else $error("second token without first");

  // parameter beats never close a run
  a_param_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == tesp_pkg::K_CSI_PARAM |-> !out_ch.last_of_run)
    else $error("csi parameter flagged last");

endmodule

`default_nettype wire
